/* sv/tcs_pkg.sv */
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types, constants and helpers for the touch coordinate scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package tcs_pkg;

  localparam int unsigned RawWidth   = 12;
  localparam int unsigned CoordWidth = 16;
  localparam int unsigned ValWidth   = 16;
  localparam int unsigned DenWidth   = RawWidth + 1;
  localparam int unsigned ProdWidth  = 30;
  localparam int unsigned MagWidth   = 28;
  localparam int unsigned QuoWidth   = 17;
  localparam int unsigned CntWidth   = $clog2(QuoWidth);
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned OrientWidth = 3;

  // Pressure thresholds, the full-scale raw conversion value and reset values.
  localparam logic [RawWidth-1:0] TouchLevel   = 12'd400;
  localparam logic [RawWidth-1:0] ReleaseLevel = 12'd200;
  localparam logic [15:0]         RawMax       = 16'd4095;
  localparam logic [RawWidth-1:0] CalHighReset = RawMax[RawWidth-1:0];
  localparam logic [RawWidth-1:0] ScreenReset  = 12'd100;

  localparam int unsigned OrientSwap = 0;
  localparam int unsigned OrientInvX = 1;
  localparam int unsigned OrientInvY = 2;

  localparam logic [CoordWidth-1:0] CoordNone = '1;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_X_LOW  = 3'd0,
    CFG_X_HIGH = 3'd1,
    CFG_Y_LOW  = 3'd2,
    CFG_Y_HIGH = 3'd3,
    CFG_WIDTH  = 3'd4,
    CFG_HEIGHT = 3'd5,
    CFG_ORIENT = 3'd6
  } cfg_index_e;

  typedef struct packed {
    logic [RawWidth-1:0]    x_low;
    logic [RawWidth-1:0]    x_high;
    logic [RawWidth-1:0]    y_low;
    logic [RawWidth-1:0]    y_high;
    logic [RawWidth-1:0]    width;
    logic [RawWidth-1:0]    height;
    logic [OrientWidth-1:0] orient;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load;
    logic axis;
    logic mul;
    logic chk;
    logic div_step;
    logic store_x;
    logic finish;
  } dp_cmd_t;

  // Turns an unsigned quotient magnitude into the saturated signed coordinate.
  function automatic logic [CoordWidth-1:0] sat_quot(
    input logic [QuoWidth-1:0] mag,
    input logic                neg,
    input logic                sat,
    input logic                zero
  );
    logic [CoordWidth-1:0] res;
    if (zero) begin
      res = '0;
    end else if (!neg) begin
      if (sat || (mag > QuoWidth'(32767))) res = 16'h7FFF;
      else res = mag[CoordWidth-1:0];
    end else begin
      if (sat || (mag > QuoWidth'(32768))) res = 16'h8000;
      else res = CoordWidth'(QuoWidth'(0) - mag);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* sv/tcs_cfg_regs.sv */
// ----------------------------------------------------------------------------
// tcs_cfg_regs
// Calibration, screen size and orientation registers behind a write port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcs_cfg_regs
  import tcs_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0] cfg_index_i,
  input  wire logic [RawWidth-1:0]    cfg_wdata_i,
  output cfg_t                        cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_X_LOW:  cfg_d.x_low  = cfg_wdata_i;
        CFG_X_HIGH: cfg_d.x_high = cfg_wdata_i;
        CFG_Y_LOW:  cfg_d.y_low  = cfg_wdata_i;
        CFG_Y_HIGH: cfg_d.y_high = cfg_wdata_i;
        CFG_WIDTH:  cfg_d.width  = cfg_wdata_i;
        CFG_HEIGHT: cfg_d.height = cfg_wdata_i;
        CFG_ORIENT: cfg_d.orient = cfg_wdata_i[OrientWidth-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_low  <= '0;
      cfg_q.x_high <= CalHighReset;
      cfg_q.y_low  <= '0;
      cfg_q.y_high <= CalHighReset;
      cfg_q.width  <= ScreenReset;
      cfg_q.height <= ScreenReset;
      cfg_q.orient <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* sv/tcs_ctrl.sv */
// ----------------------------------------------------------------------------
// tcs_ctrl
// Sequencer: multiply, set-up and divide steps for each axis, then finish.
// ----------------------------------------------------------------------------
`default_nettype none

module tcs_ctrl
  import tcs_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output dp_cmd_t   cmd_o
);

  state_e              state_q, state_d;
  logic                axis_q, axis_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    cnt_d       = cnt_q;
    // A waiting result is dropped from the register once it is transferred.
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.axis  = axis_q;
    in_stall_o  = (state_q != ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          axis_d     = 1'b0;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul     = 1'b1;
        // The x quotient is still in the divider when y starts.
        cmd_o.store_x = axis_q;
        state_d       = ST_CHK;
      end
      ST_CHK: begin
        cmd_o.chk = 1'b1;
        cnt_d     = '0;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CntWidth'(QuoWidth - 1)) begin
          if (!axis_q) begin
            axis_d  = 1'b1;
            state_d = ST_MUL;
          end else begin
            state_d = ST_FIN;
          end
        end else begin
          cnt_d = cnt_q + CntWidth'(1);
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* sv/tcs_datapath.sv */
// ----------------------------------------------------------------------------
// tcs_datapath
// Orientation, multiplier, shared restoring divider, hysteresis and results.
// ----------------------------------------------------------------------------
`default_nettype none

module tcs_datapath
  import tcs_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  cfg_t                       cfg_i,
  input  dp_cmd_t                    cmd_i,
  input  wire logic [RawWidth-1:0]   raw_x_i,
  input  wire logic [RawWidth-1:0]   raw_y_i,
  input  wire logic [RawWidth-1:0]   raw_pressure_i,
  output logic [CoordWidth-1:0]      scaled_x_o,
  output logic [CoordWidth-1:0]      scaled_y_o,
  output logic [CoordWidth-1:0]      reported_x_o,
  output logic [CoordWidth-1:0]      reported_y_o,
  output logic                       is_touched_o,
  output logic                       press_event_o,
  output logic                       release_event_o,
  output logic [CoordWidth-1:0]      press_at_x_o,
  output logic [CoordWidth-1:0]      press_at_y_o,
  output logic [CoordWidth-1:0]      release_at_x_o,
  output logic [CoordWidth-1:0]      release_at_y_o
);

  // Sample registers
  logic [ValWidth-1:0] val_x_q, val_y_q;
  logic [RawWidth-1:0] pres_q;
  logic [ValWidth-1:0] inv_x, inv_y;

  // Product and divider registers
  logic [ProdWidth-1:0] prod_q;
  logic [DenWidth-1:0]  den_q;
  logic [RawWidth-1:0]  rem_q, dvs_q;
  logic [QuoWidth-1:0]  quo_q;
  logic                 sat_q, neg_q, zero_q;
  logic [CoordWidth-1:0] res_x_q;

  // Touch state
  logic                  touched_q;
  logic [CoordWidth-1:0] press_x_q, press_y_q, rel_x_q, rel_y_q;

  // Output payload
  logic [CoordWidth-1:0] sx_out_q, sy_out_q, rx_out_q, ry_out_q;
  logic                  touched_out_q, press_out_q, release_out_q;
  logic [CoordWidth-1:0] px_out_q, py_out_q, qx_out_q, qy_out_q;

  // Axis selection and multiply
  logic [ValWidth-1:0]  v_sel;
  logic [RawWidth-1:0]  lo_sel, hi_sel, size_sel;
  logic [ValWidth:0]    diff;
  logic [ProdWidth-1:0] prod;
  logic [DenWidth-1:0]  den;

  // Divider set-up and step
  logic [MagWidth-1:0]  nmag;
  logic [RawWidth-1:0]  dmag;
  logic [RawWidth:0]    trial, trial_sub;
  logic                 trial_ge;
  logic [CoordWidth-1:0] cur_res;

  // Hysteresis
  logic do_press, do_release, touched_next;

  assign inv_x = cfg_i.orient[OrientInvX] ?
                 ({4'b0, cfg_i.x_high} - {4'b0, raw_x_i}) : {4'b0, raw_x_i};
  assign inv_y = cfg_i.orient[OrientInvY] ?
                 ({4'b0, cfg_i.y_high} - {4'b0, raw_y_i}) : {4'b0, raw_y_i};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (cfg_i.orient[OrientSwap]) begin
        val_x_q <= inv_y;
        val_y_q <= inv_x;
      end else begin
        val_x_q <= inv_x;
        val_y_q <= inv_y;
      end
      pres_q <= raw_pressure_i;
    end
  end

  assign v_sel    = cmd_i.axis ? val_y_q      : val_x_q;
  assign lo_sel   = cmd_i.axis ? cfg_i.y_low  : cfg_i.x_low;
  assign hi_sel   = cmd_i.axis ? cfg_i.y_high : cfg_i.x_high;
  assign size_sel = cmd_i.axis ? cfg_i.height : cfg_i.width;

  // Two's complement: the low product bits are the same signed or unsigned.
  assign diff = {1'b0, v_sel} - {5'b0, lo_sel};
  assign prod = {{(ProdWidth - ValWidth - 1){diff[ValWidth]}}, diff} *
                {{(ProdWidth - RawWidth){1'b0}}, size_sel};
  assign den  = {1'b0, hi_sel} - {1'b0, lo_sel};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= prod;
      den_q  <= den;
    end
  end

  // Magnitudes fit 28 bits for the numerator and 12 for the denominator.
  assign nmag = prod_q[ProdWidth-1] ? MagWidth'(~prod_q + ProdWidth'(1))
                                    : prod_q[MagWidth-1:0];
  assign dmag = den_q[DenWidth-1] ? RawWidth'(~den_q + DenWidth'(1))
                                  : den_q[RawWidth-1:0];

  assign trial     = {rem_q, quo_q[QuoWidth-1]};
  assign trial_ge  = trial >= {1'b0, dvs_q};
  assign trial_sub = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.chk) begin
      // If the top bits already reach the divisor, the quotient needs more
      // than 17 bits and the result saturates whatever the sign (a zero divisor gives zero).
      sat_q  <= {1'b0, nmag[MagWidth-1:QuoWidth]} >= dmag;
      neg_q  <= prod_q[ProdWidth-1] ^ den_q[DenWidth-1];
      zero_q <= (den_q == '0);
      rem_q  <= {1'b0, nmag[MagWidth-1:QuoWidth]};
      quo_q  <= nmag[QuoWidth-1:0];
      dvs_q  <= dmag;
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? trial_sub[RawWidth-1:0] : trial[RawWidth-1:0];
      quo_q <= {quo_q[QuoWidth-2:0], trial_ge};
    end
  end

  assign cur_res = sat_quot(quo_q, neg_q, sat_q, zero_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_x) begin
      res_x_q <= cur_res;
    end
  end

  assign do_release   = touched_q && (pres_q < ReleaseLevel);
  assign do_press     = !touched_q && (pres_q > TouchLevel);
  assign touched_next = (touched_q && !do_release) || do_press;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touched_q <= 1'b0;
      press_x_q <= CoordNone;
      press_y_q <= CoordNone;
      rel_x_q   <= CoordNone;
      rel_y_q   <= CoordNone;
    end else if (cmd_i.finish) begin
      touched_q <= touched_next;
      if (do_press) begin
        press_x_q <= res_x_q;
        press_y_q <= cur_res;
      end
      if (do_release) begin
        rel_x_q <= res_x_q;
        rel_y_q <= cur_res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      sx_out_q      <= res_x_q;
      sy_out_q      <= cur_res;
      rx_out_q      <= touched_next ? res_x_q : CoordNone;
      ry_out_q      <= touched_next ? cur_res : CoordNone;
      touched_out_q <= touched_next;
      press_out_q   <= do_press;
      release_out_q <= do_release;
      px_out_q      <= do_press ? res_x_q : press_x_q;
      py_out_q      <= do_press ? cur_res : press_y_q;
      qx_out_q      <= do_release ? res_x_q : rel_x_q;
      qy_out_q      <= do_release ? cur_res : rel_y_q;
    end
  end

  assign scaled_x_o      = sx_out_q;
  assign scaled_y_o      = sy_out_q;
  assign reported_x_o    = rx_out_q;
  assign reported_y_o    = ry_out_q;
  assign is_touched_o    = touched_out_q;
  assign press_event_o   = press_out_q;
  assign release_event_o = release_out_q;
  assign press_at_x_o    = px_out_q;
  assign press_at_y_o    = py_out_q;
  assign release_at_x_o  = qx_out_q;
  assign release_at_y_o  = qy_out_q;

endmodule

`default_nettype wire

/* sv/touch_coordinate_scaler_with_hysteresis_unit.sv */
// ----------------------------------------------------------------------------
// touch_coordinate_scaler_with_hysteresis_unit
// Calibrates raw touch samples to screen coordinates and tracks touch state.
// ----------------------------------------------------------------------------
// Each raw sample is captured and oriented at the transfer on the input
// channel; then for each axis come a multiply step, a divider set-up step
// and 17 steps of the shared restoring divider, and a final step for the
// touch hysteresis loads the result into the output register. The block
// takes no new sample until it is through with the last one. A new sample
// is taken as soon as the previous result has been loaded, even while that
// result still waits to be transferred; if a result is still waiting when
// the next one is complete, the block holds until it is taken.
// Configuration registers take effect for the next sample when written while
// the block is idle; the user must write them only then, as the block itself
// does not enforce it.
`default_nettype none

module touch_coordinate_scaler_with_hysteresis_unit
  import tcs_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0] cfg_index_i,
  input  wire logic [RawWidth-1:0]    cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [RawWidth-1:0]    raw_x_i,
  input  wire logic [RawWidth-1:0]    raw_y_i,
  input  wire logic [RawWidth-1:0]    raw_pressure_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [CoordWidth-1:0]       scaled_x_o,
  output logic [CoordWidth-1:0]       scaled_y_o,
  output logic [CoordWidth-1:0]       reported_x_o,
  output logic [CoordWidth-1:0]       reported_y_o,
  output logic                        is_touched_o,
  output logic                        press_event_o,
  output logic                        release_event_o,
  output logic [CoordWidth-1:0]       press_at_x_o,
  output logic [CoordWidth-1:0]       press_at_y_o,
  output logic [CoordWidth-1:0]       release_at_x_o,
  output logic [CoordWidth-1:0]       release_at_y_o
);

  cfg_t    cfg;
  dp_cmd_t cmd;

  tcs_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  tcs_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .raw_x_i         (raw_x_i),
    .raw_y_i         (raw_y_i),
    .raw_pressure_i  (raw_pressure_i),
    .scaled_x_o      (scaled_x_o),
    .scaled_y_o      (scaled_y_o),
    .reported_x_o    (reported_x_o),
    .reported_y_o    (reported_y_o),
    .is_touched_o    (is_touched_o),
    .press_event_o   (press_event_o),
    .release_event_o (release_event_o),
    .press_at_x_o    (press_at_x_o),
    .press_at_y_o    (press_at_y_o),
    .release_at_x_o  (release_at_x_o),
    .release_at_y_o  (release_at_y_o)
  );

endmodule

`default_nettype wire

/* sv/tcs_checker.sv */
// ----------------------------------------------------------------------------
// tcs_checker
// Port-level checks on the touch coordinate scaler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcs_checker
  import tcs_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_stall_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [CoordWidth-1:0] scaled_x_o,
  input wire logic [CoordWidth-1:0] scaled_y_o,
  input wire logic [CoordWidth-1:0] reported_x_o,
  input wire logic [CoordWidth-1:0] reported_y_o,
  input wire logic                  is_touched_o,
  input wire logic                  press_event_o,
  input wire logic                  release_event_o,
  input wire logic [CoordWidth-1:0] press_at_x_o,
  input wire logic [CoordWidth-1:0] press_at_y_o
);

  // The block works on one sample at a time.
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again directly after a transfer");

  a_released_reports_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_touched_o |->
      reported_x_o == CoordNone && reported_y_o == CoordNone)
    else $error("reported point not cleared while released");

  a_touched_reports_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_touched_o |->
      reported_x_o == scaled_x_o && reported_y_o == scaled_y_o)
    else $error("reported point differs from scaled point while touched");

  a_press_latches_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && press_event_o |->
      is_touched_o && !release_event_o &&
      press_at_x_o == scaled_x_o && press_at_y_o == scaled_y_o)
    else $error("press event without matching state or latched point");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(scaled_x_o) && $stable(is_touched_o))
    else $error("stalled result changed");

endmodule

bind touch_coordinate_scaler_with_hysteresis_unit tcs_checker u_tcs_checker (.*);

`default_nettype wire

/* tb/tb_touch_coordinate_scaler_with_hysteresis_unit.sv */
// ----------------------------------------------------------------------------
// tb_touch_coordinate_scaler_with_hysteresis_unit
// Self-checking bench for the touch coordinate scaler. Raw samples are
// driven through the input channel while a tracker works out the calibrated,
// saturated point and the touch hysteresis for each accepted transfer. Every
// result transfer is compared field by field against the oldest prediction.
// A short directed run covers the bounds, saturation, equal calibration
// limits, inversion wrap and the pressure levels; random phases follow under
// several calibration settings and idling patterns on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_touch_coordinate_scaler_with_hysteresis_unit;
  import tcs_pkg::*;

  localparam int ClkHalf      = 10;
  localparam int SettleCycles = 50;
  localparam int ItemsPerSet  = 225;
  localparam int MaxReports   = 40;
  localparam logic [CfgIdxWidth-1:0] CfgSpare = '1;

  typedef struct packed {
    logic [CoordWidth-1:0] scaled_x;
    logic [CoordWidth-1:0] scaled_y;
    logic [CoordWidth-1:0] reported_x;
    logic [CoordWidth-1:0] reported_y;
    logic                  is_touched;
    logic                  press_event;
    logic                  release_event;
    logic [CoordWidth-1:0] press_at_x;
    logic [CoordWidth-1:0] press_at_y;
    logic [CoordWidth-1:0] release_at_x;
    logic [CoordWidth-1:0] release_at_y;
  } scaled_result_t;

  typedef logic [CoordWidth-1:0] point_fields_t [11];

  // Tracks calibration and touch state, and holds the points still awaited.
  class touch_point_tracker;
    cfg_t                  cal;
    bit                    touched;
    logic [CoordWidth-1:0] press_x, press_y, rel_x, rel_y;
    scaled_result_t        awaited_points[$];
    int                    failures;

    function new();
      cal = '{x_low: '0, x_high: CalHighReset, y_low: '0, y_high: CalHighReset,
              width: ScreenReset, height: ScreenReset, orient: '0};
      touched  = 1'b0;
      press_x  = CoordNone;
      press_y  = CoordNone;
      rel_x    = CoordNone;
      rel_y    = CoordNone;
      failures = 0;
    endfunction

    function void set_reg(logic [CfgIdxWidth-1:0] idx, logic [RawWidth-1:0] val);
      case (cfg_index_e'(idx))
        CFG_X_LOW:  cal.x_low  = val;
        CFG_X_HIGH: cal.x_high = val;
        CFG_Y_LOW:  cal.y_low  = val;
        CFG_Y_HIGH: cal.y_high = val;
        CFG_WIDTH:  cal.width  = val;
        CFG_HEIGHT: cal.height = val;
        CFG_ORIENT: cal.orient = val[OrientWidth-1:0];
        default: ;
      endcase
    endfunction

    function logic [CoordWidth-1:0] scale_axis(logic [ValWidth-1:0] v,
                                               logic [RawWidth-1:0] lo,
                                               logic [RawWidth-1:0] hi,
                                               logic [RawWidth-1:0] size);
      longint span;
      longint quot;
      span = longint'(hi) - longint'(lo);
      if (span == 0) return '0;
      quot = ((longint'(v) - longint'(lo)) * longint'(size)) / span;
      if (quot > 32767) quot = 32767;
      if (quot < -32768) quot = -32768;
      return quot[CoordWidth-1:0];
    endfunction

    function void note_sample(logic [RawWidth-1:0] rx, logic [RawWidth-1:0] ry,
                              logic [RawWidth-1:0] rz);
      logic [ValWidth-1:0] vx, vy, tmp;
      scaled_result_t      p;
      vx = ValWidth'(rx);
      vy = ValWidth'(ry);
      // Inversion wraps at 16 bits when the raw value exceeds the high bound.
      if (cal.orient[OrientInvX]) vx = ValWidth'(cal.x_high) - vx;
      if (cal.orient[OrientInvY]) vy = ValWidth'(cal.y_high) - vy;
      if (cal.orient[OrientSwap]) begin
        tmp = vx;
        vx  = vy;
        vy  = tmp;
      end
      p.scaled_x      = scale_axis(vx, cal.x_low, cal.x_high, cal.width);
      p.scaled_y      = scale_axis(vy, cal.y_low, cal.y_high, cal.height);
      p.press_event   = 1'b0;
      p.release_event = 1'b0;
      if (touched) begin
        if (rz < ReleaseLevel) begin
          touched         = 1'b0;
          p.release_event = 1'b1;
          rel_x           = p.scaled_x;
          rel_y           = p.scaled_y;
        end
      end else if (rz > TouchLevel) begin
        touched       = 1'b1;
        p.press_event = 1'b1;
        press_x       = p.scaled_x;
        press_y       = p.scaled_y;
      end
      p.is_touched   = touched;
      p.reported_x   = touched ? p.scaled_x : CoordNone;
      p.reported_y   = touched ? p.scaled_y : CoordNone;
      p.press_at_x   = press_x;
      p.press_at_y   = press_y;
      p.release_at_x = rel_x;
      p.release_at_y = rel_y;
      awaited_points.push_back(p);
    endfunction

    function point_fields_t to_fields(scaled_result_t p);
      point_fields_t f;
      f = '{p.scaled_x, p.scaled_y, p.reported_x, p.reported_y,
            CoordWidth'(p.is_touched), CoordWidth'(p.press_event),
            CoordWidth'(p.release_event), p.press_at_x, p.press_at_y,
            p.release_at_x, p.release_at_y};
      return f;
    endfunction

    function void check_point(scaled_result_t got);
      string         names[11] = '{"scaled_x", "scaled_y", "reported_x", "reported_y",
                                   "is_touched", "press_event", "release_event",
                                   "press_at_x", "press_at_y", "release_at_x",
                                   "release_at_y"};
      point_fields_t want_f, got_f;
      if (awaited_points.size() == 0) begin
        if (failures < MaxReports)
          $display("%0t: result transfer with no sample outstanding", $time);
        failures++;
        return;
      end
      want_f = to_fields(awaited_points.pop_front());
      got_f  = to_fields(got);
      for (int i = 0; i < 11; i++) begin
        if (want_f[i] !== got_f[i]) begin
          if (failures < MaxReports)
            $display("%0t: %s expected %0d, actual %0d", $time, names[i],
                     $signed(want_f[i]), $signed(got_f[i]));
          failures++;
        end
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CfgIdxWidth-1:0] cfg_index;
  logic [RawWidth-1:0]    cfg_wdata;
  logic                   in_valid;
  logic                   in_stall;
  logic [RawWidth-1:0]    raw_x, raw_y, raw_pressure;
  logic                   out_valid;
  logic                   out_stall;
  logic [CoordWidth-1:0]  scaled_x, scaled_y, reported_x, reported_y;
  logic                   is_touched, press_event, release_event;
  logic [CoordWidth-1:0]  press_at_x, press_at_y, release_at_x, release_at_y;

  int                     idle_pct;
  int                     stall_pct;
  touch_point_tracker     points;

  touch_coordinate_scaler_with_hysteresis_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .raw_x_i        (raw_x),
    .raw_y_i        (raw_y),
    .raw_pressure_i (raw_pressure),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .scaled_x_o     (scaled_x),
    .scaled_y_o     (scaled_y),
    .reported_x_o   (reported_x),
    .reported_y_o   (reported_y),
    .is_touched_o   (is_touched),
    .press_event_o  (press_event),
    .release_event_o(release_event),
    .press_at_x_o   (press_at_x),
    .press_at_y_o   (press_at_y),
    .release_at_x_o (release_at_x),
    .release_at_y_o (release_at_y)
  );

  always begin
    #ClkHalf clk = 1'b1;
    #ClkHalf clk = 1'b0;
  end

  initial begin
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall)
      points.check_point('{scaled_x: scaled_x, scaled_y: scaled_y,
                           reported_x: reported_x, reported_y: reported_y,
                           is_touched: is_touched, press_event: press_event,
                           release_event: release_event, press_at_x: press_at_x,
                           press_at_y: press_at_y, release_at_x: release_at_x,
                           release_at_y: release_at_y});
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_sample(input logic [RawWidth-1:0] x, input logic [RawWidth-1:0] y,
                             input logic [RawWidth-1:0] z);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    raw_x        <= x;
    raw_y        <= y;
    raw_pressure <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    points.note_sample(x, y, z);
    @(negedge clk);
  endtask

  // Holds the sender off until every outstanding result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    while (points.awaited_points.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CfgIdxWidth-1:0] idx, input logic [RawWidth-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    points.set_reg(idx, val);
  endtask

  task automatic apply_setting(input cfg_t s);
    put_reg(CFG_X_LOW, s.x_low);
    put_reg(CFG_X_HIGH, s.x_high);
    put_reg(CFG_Y_LOW, s.y_low);
    put_reg(CFG_Y_HIGH, s.y_high);
    put_reg(CFG_WIDTH, s.width);
    put_reg(CFG_HEIGHT, s.height);
    put_reg(CFG_ORIENT, RawWidth'(s.orient));
    // The unused index must leave every register alone.
    put_reg(CfgSpare, RawWidth'($urandom_range(4095)));
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t random_setting(input int k);
    cfg_t s;
    s.x_low  = RawWidth'($urandom_range(4095));
    s.x_high = RawWidth'($urandom_range(4095));
    s.y_low  = RawWidth'($urandom_range(4095));
    s.y_high = RawWidth'($urandom_range(4095));
    s.width  = RawWidth'($urandom_range(2048));
    s.height = RawWidth'($urandom_range(2048));
    s.orient = OrientWidth'(k);
    if ($urandom_range(3) == 0) s.x_high = s.x_low;
    if ($urandom_range(3) == 0) s.y_high = s.y_low;
    if (k == 0)
      s = '{x_low: '0, x_high: '1, y_low: '0, y_high: '1,
            width: 12'd2048, height: 12'd2048, orient: s.orient};
    else if (k == 1)
      s = '{x_low: '1, x_high: '0, y_low: '1, y_high: '0,
            width: '0, height: 12'd2048, orient: s.orient};
    return s;
  endfunction

  function automatic logic [RawWidth-1:0] pick_raw();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return RawWidth'($urandom_range(4095));
  endfunction

  // Pressure mostly follows press and release patterns around the two levels.
  function automatic logic [RawWidth-1:0] pick_pressure();
    int r;
    r = $urandom_range(99);
    if (r < 25) return RawWidth'($urandom_range(4095));
    if (r < 50) return RawWidth'($urandom_range(405, 195));
    if (r < 80) return RawWidth'($urandom_range(4095, 401));
    return RawWidth'($urandom_range(199));
  endfunction

  task automatic run_items(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(199) == 0) drain();
      send_sample(pick_raw(), pick_raw(), pick_pressure());
    end
  endtask

  initial begin
    #(20_000_000);
    $display("** touch_coordinate_scaler_with_hysteresis_unit: FAILED **");
    $finish;
  end

  initial begin
    points       = new();
    idle_pct     = 0;
    stall_pct    = 0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    raw_x        = '0;
    raw_y        = '0;
    raw_pressure = '0;
    out_stall    = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset calibration: field extremes and both pressure levels on each side.
    send_sample(12'd0, 12'd0, 12'd0);
    send_sample(12'd4095, 12'd4095, 12'd4095);
    send_sample(12'd2048, 12'd1024, 12'd400);
    send_sample(12'd1, 12'd2, 12'd200);
    send_sample(12'd3, 12'd4, 12'd199);
    send_sample(12'd100, 12'd100, 12'd400);
    send_sample(12'd4095, 12'd0, 12'd401);
    send_sample(12'd0, 12'd4095, 12'd0);

    // A one-count span saturates both ways; equal y bounds give zero.
    drain();
    apply_setting('{x_low: 12'd4000, x_high: 12'd4001, y_low: 12'd77, y_high: 12'd77,
                    width: 12'd2048, height: 12'd2048, orient: '0});
    send_sample(12'd0, 12'd123, 12'd4095);
    send_sample(12'd4095, 12'd4095, 12'd0);

    // Both axes inverted and swapped, with raw values past the high bound.
    drain();
    apply_setting('{x_low: 12'd0, x_high: 12'd1000, y_low: 12'd10, y_high: 12'd3000,
                    width: 12'd2048, height: 12'd1, orient: '1});
    send_sample(12'd4095, 12'd0, 12'd4095);
    send_sample(12'd0, 12'd4095, 12'd300);
    send_sample(12'd1000, 12'd3000, 12'd199);
    send_sample(12'd2345, 12'd17, 12'd401);

    // Low bound above the high one, zero width, x inverted only.
    drain();
    apply_setting('{x_low: '1, x_high: '0, y_low: '1, y_high: '0,
                    width: '0, height: 12'd2048, orient: OrientWidth'(1 << OrientInvX)});
    send_sample(12'd4095, 12'd4095, 12'd0);
    send_sample(12'd0, 12'd0, 12'd4095);
    send_sample(12'd4095, 12'd0, 12'd150);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      for (int s = 0; s < 2; s++) begin
        drain();
        apply_setting(random_setting(ph * 2 + s));
        run_items(ItemsPerSet);
      end
    end

    drain();
    if (points.failures == 0)
      $display("** touch_coordinate_scaler_with_hysteresis_unit: PASSED **");
    else
      $display("** touch_coordinate_scaler_with_hysteresis_unit: FAILED **");
    $finish;
  end

endmodule

/* files.f */
sv/tcs_pkg.sv
sv/tcs_cfg_regs.sv
sv/tcs_ctrl.sv
sv/tcs_datapath.sv
sv/touch_coordinate_scaler_with_hysteresis_unit.sv
sv/tcs_checker.sv
tb/tb_touch_coordinate_scaler_with_hysteresis_unit.sv
